FILE: sv/json_string_unescape_utf8_unit_assert.svh
// assertion macros used by the checker file
`ifndef JSON_STRING_UNESCAPE_UTF8_UNIT_ASSERT_SVH
`define JSON_STRING_UNESCAPE_UTF8_UNIT_ASSERT_SVH

// same-cycle implication, held off while in reset
`define JSU_ASSERT_NOW(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("jsu assertion failed");

// next-cycle implication, held off while in reset
`define JSU_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("jsu assertion failed");

`endif

FILE: sv/jsu_pkg.sv
`default_nettype none

package jsu_pkg;

    // result kinds
    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_END  = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    // most results one input item can cause
    localparam int MAX_RESULTS = 4;

    // the results of one input item, first result in slot 0
    typedef struct packed {
        logic [1:0]                  last_idx;
        logic [MAX_RESULTS-1:0][7:0] data;
        logic [MAX_RESULTS-1:0][1:0] kinds;
    } job_t;

endpackage

`default_nettype wire

FILE: sv/jsu_front.sv
`default_nettype none

module jsu_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          accept,
    input  wire logic [7:0]    in_byte,
    input  wire logic          open_quote,
    output logic               push,
    output jsu_pkg::job_t      job
);
    import jsu_pkg::*;

    // parser modes
    localparam logic [2:0] M_IDLE    = 3'd0;
    localparam logic [2:0] M_TEXT    = 3'd1;
    localparam logic [2:0] M_ESC     = 3'd2;
    localparam logic [2:0] M_HEX1    = 3'd3;
    localparam logic [2:0] M_HIGH    = 3'd4;
    localparam logic [2:0] M_HIGH_BS = 3'd5;
    localparam logic [2:0] M_HEX2    = 3'd6;

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_U      = 8'h75;

    // outcome of one text or escape character
    typedef struct packed {
        logic       v;
        logic [7:0] data;
        logic [1:0] kind;
        logic [2:0] mode;
        logic       clear;
        logic       start_hex;
    } step_t;

    // utf-8 encoding of one code point
    typedef struct packed {
        logic [2:0]      n;
        logic [3:0][7:0] data;
    } enc_t;

    logic [2:0]  mode_reg, mode_next;
    logic [1:0]  hex_count_reg, hex_count_next;
    logic [15:0] code_unit_reg, code_unit_next;
    logic [15:0] pending_high_reg, pending_high_next;

    step_t       s;
    enc_t        enc;
    logic        use_enc;
    logic [20:0] enc_cp;
    logic        sgl_v;
    logic [7:0]  sgl_byte;
    logic [1:0]  sgl_kind;
    logic [4:0]  hex;
    logic [15:0] cu_new;
    logic [20:0] cp_pair;
    logic [2:0]  enc_n;
    logic [2:0]  total;

    // plain text character
    function automatic step_t do_text(input logic [7:0] b);
        step_t r;
        r = '{v: 1'b0, data: 8'h00, kind: KIND_DATA, mode: M_TEXT,
              clear: 1'b0, start_hex: 1'b0};
        priority if (b == CH_BSLASH) begin
            r.mode = M_ESC;
        end else if (b == CH_QUOTE) begin
            r.v = 1'b1;
            r.kind = KIND_END;
            r.clear = 1'b1;
        end else if (b < 8'd32) begin
            r.v = 1'b1;
            r.kind = KIND_ERR;
            r.clear = 1'b1;
        end else begin
            r.v = 1'b1;
            r.data = b;
        end
        return r;
    endfunction

    // character after a backslash
    function automatic step_t do_escape(input logic [7:0] b);
        step_t r;
        r = '{v: 1'b0, data: 8'h00, kind: KIND_DATA, mode: M_TEXT,
              clear: 1'b0, start_hex: 1'b0};
        unique case (b)
            8'h22, 8'h5C, 8'h2F: begin
                r.v = 1'b1;
                r.data = b;
            end
            8'h62: begin
                r.v = 1'b1;
                r.data = 8'h08;
            end
            8'h66: begin
                r.v = 1'b1;
                r.data = 8'h0C;
            end
            8'h6E: begin
                r.v = 1'b1;
                r.data = 8'h0A;
            end
            8'h72: begin
                r.v = 1'b1;
                r.data = 8'h0D;
            end
            8'h74: begin
                r.v = 1'b1;
                r.data = 8'h09;
            end
            CH_U: begin
                r.mode = M_HEX1;
                r.start_hex = 1'b1;
            end
            8'h00: begin
                r.v = 1'b1;
                r.kind = KIND_ERR;
                r.clear = 1'b1;
            end
            default: begin
                // unknown escape is dropped
                r.v = 1'b0;
            end
        endcase
        return r;
    endfunction

    // hex digit: {ok, value}
    function automatic logic [4:0] hex_digit(input logic [7:0] b);
        logic [7:0] d;
        d = 8'h00;
        priority if (b >= 8'h30 && b <= 8'h39) begin
            d = b - 8'h30;
            return {1'b1, d[3:0]};
        end else if (b >= 8'h61 && b <= 8'h66) begin
            d = b - 8'h57;
            return {1'b1, d[3:0]};
        end else if (b >= 8'h41 && b <= 8'h46) begin
            d = b - 8'h37;
            return {1'b1, d[3:0]};
        end else begin
            return 5'b0_0000;
        end
    endfunction

    // utf-8 encoder
    function automatic enc_t encode(input logic [20:0] cp);
        enc_t r;
        r.n = 3'd1;
        r.data = '0;
        priority if (cp <= 21'h00007F) begin
            r.data[0] = cp[7:0];
        end else if (cp < 21'h000800) begin
            r.n = 3'd2;
            r.data[0] = {3'b110, cp[10:6]};
            r.data[1] = {2'b10, cp[5:0]};
        end else if (cp < 21'h010000) begin
            r.n = 3'd3;
            r.data[0] = {4'b1110, cp[15:12]};
            r.data[1] = {2'b10, cp[11:6]};
            r.data[2] = {2'b10, cp[5:0]};
        end else begin
            r.n = 3'd4;
            r.data[0] = {5'b11110, cp[20:18]};
            r.data[1] = {2'b10, cp[17:12]};
            r.data[2] = {2'b10, cp[11:6]};
            r.data[3] = {2'b10, cp[5:0]};
        end
        return r;
    endfunction

    // digit merge and surrogate pair arithmetic
    assign hex     = hex_digit(in_byte);
    assign cu_new  = {code_unit_reg[11:0], hex[3:0]};
    assign cp_pair = {1'b0, pending_high_reg[9:0], 10'b0} + {5'b0, cu_new} + 21'h002400;
    assign enc     = encode(enc_cp);

    // parser next state and result selection
    always_comb
    begin
        mode_next         = mode_reg;
        hex_count_next    = hex_count_reg;
        code_unit_next    = code_unit_reg;
        pending_high_next = pending_high_reg;
        use_enc           = 1'b0;
        enc_cp            = 21'h0;
        s = '{v: 1'b0, data: 8'h00, kind: KIND_DATA, mode: M_TEXT,
              clear: 1'b0, start_hex: 1'b0};

        if (open_quote) begin
            mode_next         = M_TEXT;
            hex_count_next    = 2'd0;
            code_unit_next    = 16'h0;
            pending_high_next = 16'h0;
        end else begin
            unique case (mode_reg)
                M_TEXT: begin
                    s = do_text(in_byte);
                end
                M_ESC: begin
                    s = do_escape(in_byte);
                end
                M_HEX1: begin
                    if (!hex[4]) begin
                        s.v = 1'b1;
                        s.kind = KIND_ERR;
                        s.clear = 1'b1;
                    end else if (hex_count_reg == 2'd3) begin
                        hex_count_next = 2'd0;
                        code_unit_next = 16'h0;
                        if (cu_new >= 16'hD800 && cu_new <= 16'hDBFF) begin
                            pending_high_next = cu_new;
                            s.mode = M_HIGH;
                        end else begin
                            use_enc = 1'b1;
                            enc_cp = {5'b0, cu_new};
                        end
                    end else begin
                        hex_count_next = hex_count_reg + 2'd1;
                        code_unit_next = cu_new;
                        s.mode = M_HEX1;
                    end
                end
                M_HIGH: begin
                    if (in_byte == CH_BSLASH) begin
                        s.mode = M_HIGH_BS;
                    end else begin
                        use_enc = 1'b1;
                        enc_cp = {5'b0, pending_high_reg};
                        pending_high_next = 16'h0;
                        s = do_text(in_byte);
                    end
                end
                M_HIGH_BS: begin
                    if (in_byte == CH_U) begin
                        s.mode = M_HEX2;
                        s.start_hex = 1'b1;
                    end else begin
                        use_enc = 1'b1;
                        enc_cp = {5'b0, pending_high_reg};
                        pending_high_next = 16'h0;
                        s = do_escape(in_byte);
                    end
                end
                M_HEX2: begin
                    if (!hex[4]) begin
                        s.v = 1'b1;
                        s.kind = KIND_ERR;
                        s.clear = 1'b1;
                    end else if (hex_count_reg == 2'd3) begin
                        if (cp_pair >= 21'h110000) begin
                            s.v = 1'b1;
                            s.kind = KIND_ERR;
                            s.clear = 1'b1;
                        end else begin
                            use_enc = 1'b1;
                            enc_cp = cp_pair;
                            pending_high_next = 16'h0;
                            code_unit_next = 16'h0;
                            hex_count_next = 2'd0;
                        end
                    end else begin
                        hex_count_next = hex_count_reg + 2'd1;
                        code_unit_next = cu_new;
                        s.mode = M_HEX2;
                    end
                end
                default: begin
                    // idle: byte without opening quote is ignored
                    s.mode = mode_reg;
                end
            endcase

            // apply the character outcome
            if (s.clear) begin
                mode_next         = M_IDLE;
                hex_count_next    = 2'd0;
                code_unit_next    = 16'h0;
                pending_high_next = 16'h0;
            end else begin
                mode_next = s.mode;
                if (s.start_hex) begin
                    hex_count_next = 2'd0;
                    code_unit_next = 16'h0;
                end
            end
        end
    end

    // single result trails any encoded bytes
    assign sgl_v    = s.v & ~open_quote;
    assign sgl_byte = s.data;
    assign sgl_kind = s.kind;
    assign enc_n    = (use_enc && !open_quote) ? enc.n : 3'd0;
    assign total    = enc_n + {2'b0, sgl_v};

    // job assembly
    always_comb
    begin
        job.last_idx = 2'(total - 3'd1);
        for (int i = 0; i < MAX_RESULTS; i++) begin
            if (3'(i) < enc_n) begin
                job.data[i]  = enc.data[i];
                job.kinds[i] = KIND_DATA;
            end else begin
                job.data[i]  = sgl_byte;
                job.kinds[i] = sgl_kind;
            end
        end
    end

    assign push = accept && (total != 3'd0);

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg         <= M_IDLE;
            hex_count_reg    <= 2'd0;
            code_unit_reg    <= 16'h0;
            pending_high_reg <= 16'h0;
        end else if (accept) begin
            mode_reg         <= mode_next;
            hex_count_reg    <= hex_count_next;
            code_unit_reg    <= code_unit_next;
            pending_high_reg <= pending_high_next;
        end
    end

endmodule

`default_nettype wire

FILE: sv/jsu_queue.sv
`default_nettype none

module jsu_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  jsu_pkg::job_t      wr_job,
    input  wire logic          pop,
    output jsu_pkg::job_t      rd_job,
    output logic               full,
    output logic               empty
);
    import jsu_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    job_t          slots_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full   = (count_reg == CW'(DEPTH));
    assign empty  = (count_reg == '0);
    assign rd_job = slots_reg[rd_ptr_reg];

    // pointer wrap
    assign wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;

    // occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    // slot storage
    always_ff @(posedge clk)
    begin
        if (push) begin
            slots_reg[wr_ptr_reg] <= wr_job;
        end
    end

    // pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_next;
            end
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

FILE: sv/jsu_back.sv
`default_nettype none

module jsu_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  jsu_pkg::job_t      q_job,
    input  wire logic          q_empty,
    output logic               q_pop,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [7:0]         out_byte,
    output logic [1:0]         kind,
    output logic               run_last
);
    import jsu_pkg::*;

    job_t       job_reg;
    logic [1:0] idx_reg;
    logic       busy_reg;
    logic       at_last;
    logic       out_take;

    assign at_last   = (idx_reg == job_reg.last_idx);
    assign out_take  = busy_reg && out_ready;
    assign q_pop     = !q_empty && (!busy_reg || (out_take && at_last));

    // result slot under the cursor
    assign out_valid = busy_reg;
    assign out_byte  = job_reg.data[idx_reg];
    assign kind      = job_reg.kinds[idx_reg];
    assign run_last  = at_last;

    // job holding register
    always_ff @(posedge clk)
    begin
        if (q_pop) begin
            job_reg <= q_job;
        end
    end

    // result cursor
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            idx_reg  <= 2'd0;
        end else if (q_pop) begin
            busy_reg <= 1'b1;
            idx_reg  <= 2'd0;
        end else if (out_take) begin
            if (at_last) begin
                busy_reg <= 1'b0;
                idx_reg  <= 2'd0;
            end else begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: sv/json_string_unescape_utf8_unit.sv
// channel  | handshake             | payload
// ---------+-----------------------+------------------------------
// input    | in_valid / in_ready   | in_byte[7:0], open_quote
// output   | out_valid / out_ready | out_byte[7:0], kind[1:0], run_last
//
// one input item is taken per cycle while the job queue has room
// each item leaves zero to four results; the back end sends one result per cycle
// while out_ready is high, so sustained input rate is one item per cycle when items
// give at most one result; items pass the queue slot and job_reg before results show
// rst_n clears parser state, queue and result cursor at once; no clearing pass
// a stalled output fills the queue, after which in_ready drops
`default_nettype none

module json_string_unescape_utf8_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] in_byte,
    input  wire logic       open_quote,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      out_byte,
    output logic [1:0]      kind,
    output logic            run_last
);
    import jsu_pkg::*;

    logic  accept;
    logic  push;
    logic  pop;
    logic  full;
    logic  empty;
    job_t  wr_job;
    job_t  rd_job;

    assign in_ready = !full;
    assign accept   = in_valid && in_ready;

    // parser and result builder
    jsu_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .in_byte    (in_byte),
        .open_quote (open_quote),
        .push       (push),
        .job        (wr_job)
    );

    // job queue between parser and serializer
    jsu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_job (wr_job),
        .pop    (pop),
        .rd_job (rd_job),
        .full   (full),
        .empty  (empty)
    );

    // result serializer
    jsu_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_job     (rd_job),
        .q_empty   (empty),
        .q_pop     (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .kind      (kind),
        .run_last  (run_last)
    );

endmodule

`default_nettype wire

FILE: sv/jsu_checker.sv
`default_nettype none
`include "json_string_unescape_utf8_unit_assert.svh"

module jsu_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic [7:0] in_byte,
    input wire logic       open_quote,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] out_byte,
    input wire logic [1:0] kind,
    input wire logic       run_last
);
    import jsu_pkg::*;

    logic end_or_err;

    assign end_or_err = (kind == KIND_END) || (kind == KIND_ERR);

    // no result kind beyond the three defined
    `JSU_ASSERT_NOW(a_kind_legal, clk, rst_n, out_valid, kind != 2'd3)

    // end and error results close their item and carry a zero byte
    `JSU_ASSERT_NOW(a_term_last, clk, rst_n, out_valid && end_or_err,
                    run_last && (out_byte == 8'h00))

    // a result that is not taken is held
    `JSU_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
                     out_valid && $stable(out_byte) && $stable(kind) && $stable(run_last))

    // a result is never shown straight out of reset
    `JSU_ASSERT_NEXT(a_reset_quiet, clk, rst_n, $rose(rst_n), !out_valid)

endmodule

bind json_string_unescape_utf8_unit jsu_checker u_jsu_checker (.*);

`default_nettype wire

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import jsu_pkg::*;

    localparam int CLK_PERIOD   = 20;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 16;

    // characters with a meaning inside a string literal
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_Q      = 8'h71;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;

    // scanner states of the string decoder
    typedef enum logic [2:0] {
        SCAN_IDLE,
        SCAN_TEXT,
        SCAN_ESC,
        SCAN_HEX1,
        SCAN_HIGH,
        SCAN_HIGH_BS,
        SCAN_HEX2
    } scan_state_e;

    // one decoded result
    typedef struct packed {
        logic [7:0] data;
        logic [1:0] kind;
        logic       is_last;
    } utf8_res_t;

    logic       clk;
    logic       rst_n      = 1'b0;
    logic       in_valid   = 1'b0;
    logic       in_ready;
    logic [7:0] in_byte    = 8'h00;
    logic       open_quote = 1'b0;
    logic       out_valid;
    logic       out_ready  = 1'b0;
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic       run_last;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int items_sent     = 0;
    int err_count      = 0;
    int cycle_count    = 0;

    // decoder state as predicted
    scan_state_e scan_state = SCAN_IDLE;
    logic [1:0]  digit_cnt  = '0;
    logic [15:0] unit_acc   = '0;
    logic [15:0] held_high  = '0;

    utf8_res_t step_res[$];
    utf8_res_t expected_bytes[$];

    json_string_unescape_utf8_unit u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_byte    (in_byte),
        .open_quote (open_quote),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .kind       (kind),
        .run_last   (run_last)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // cycle watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("** json_string_unescape_utf8_unit: FAILED **");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        err_count++;
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
    endtask

    // ---------------------------------------------------------------
    // decoder prediction
    // ---------------------------------------------------------------

    function automatic void add_res(input logic [7:0] b, input logic [1:0] k);
        utf8_res_t r;
        r.data    = b;
        r.kind    = k;
        r.is_last = 1'b0;
        step_res = {step_res, r};
    endfunction

    function automatic void scan_clear();
        scan_state = SCAN_IDLE;
        digit_cnt  = '0;
        unit_acc   = '0;
        held_high  = '0;
    endfunction

    function automatic void end_string(input logic [1:0] k);
        add_res(8'h00, k);
        scan_clear();
    endfunction

    function automatic int hex_nibble(input logic [7:0] b);
        if (b >= 8'h30 && b <= 8'h39)
            return int'(b) - 'h30;
        if (b >= 8'h61 && b <= 8'h66)
            return int'(b) - 'h61 + 10;
        if (b >= 8'h41 && b <= 8'h46)
            return int'(b) - 'h41 + 10;
        return -1;
    endfunction

    // one code point to 1..4 utf-8 bytes
    function automatic void utf8_encode(input logic [31:0] cp);
        if (cp <= 32'h7F)
        begin
            add_res(cp[7:0], KIND_DATA);
        end
        else if (cp < 32'h800)
        begin
            add_res({3'b110, cp[10:6]}, KIND_DATA);
            add_res({2'b10, cp[5:0]}, KIND_DATA);
        end
        else if (cp < 32'h10000)
        begin
            add_res({4'b1110, cp[15:12]}, KIND_DATA);
            add_res({2'b10, cp[11:6]}, KIND_DATA);
            add_res({2'b10, cp[5:0]}, KIND_DATA);
        end
        else
        begin
            add_res({5'b11110, cp[20:18]}, KIND_DATA);
            add_res({2'b10, cp[17:12]}, KIND_DATA);
            add_res({2'b10, cp[11:6]}, KIND_DATA);
            add_res({2'b10, cp[5:0]}, KIND_DATA);
        end
    endfunction

    function automatic void text_char(input logic [7:0] b);
        if (b == CH_BSLASH)
            scan_state = SCAN_ESC;
        else if (b == CH_QUOTE)
            end_string(KIND_END);
        else if (b < 8'd32)
            end_string(KIND_ERR);
        else
            add_res(b, KIND_DATA);
    endfunction

    function automatic void escape_char(input logic [7:0] b);
        scan_state = SCAN_TEXT;
        case (b)
            CH_QUOTE, CH_BSLASH, CH_SLASH: add_res(b, KIND_DATA);
            CH_B: add_res(8'h08, KIND_DATA);
            CH_F: add_res(8'h0C, KIND_DATA);
            CH_N: add_res(8'h0A, KIND_DATA);
            CH_R: add_res(8'h0D, KIND_DATA);
            CH_T: add_res(8'h09, KIND_DATA);
            CH_U:
            begin
                scan_state = SCAN_HEX1;
                digit_cnt  = '0;
                unit_acc   = '0;
            end
            CH_NUL: end_string(KIND_ERR);
            default: ;
        endcase
    endfunction

    // -1 bad digit, 1 unit complete, 0 more digits to come
    function automatic int add_digit(input logic [7:0] b);
        int v;
        v = hex_nibble(b);
        if (v < 0)
            return -1;
        unit_acc = {unit_acc[11:0], v[3:0]};
        if (digit_cnt == 2'd3)
        begin
            digit_cnt = '0;
            return 1;
        end
        digit_cnt = digit_cnt + 2'd1;
        return 0;
    endfunction

    function automatic void predict_item(input logic [7:0] b, input logic oq);
        int          r;
        logic [31:0] cp;
        step_res.delete();
        if (oq)
        begin
            scan_clear();
            scan_state = SCAN_TEXT;
        end
        else
        begin
            case (scan_state)
                SCAN_TEXT: text_char(b);
                SCAN_ESC:  escape_char(b);
                SCAN_HEX1:
                begin
                    r = add_digit(b);
                    if (r < 0)
                    begin
                        end_string(KIND_ERR);
                    end
                    else if (r > 0)
                    begin
                        if (unit_acc >= 16'hD800 && unit_acc <= 16'hDBFF)
                        begin
                            held_high  = unit_acc;
                            scan_state = SCAN_HIGH;
                        end
                        else
                        begin
                            utf8_encode({16'h0, unit_acc});
                            scan_state = SCAN_TEXT;
                        end
                        unit_acc = '0;
                    end
                end
                SCAN_HIGH:
                begin
                    if (b == CH_BSLASH)
                    begin
                        scan_state = SCAN_HIGH_BS;
                    end
                    else
                    begin
                        utf8_encode({16'h0, held_high});
                        held_high  = '0;
                        scan_state = SCAN_TEXT;
                        text_char(b);
                    end
                end
                SCAN_HIGH_BS:
                begin
                    if (b == CH_U)
                    begin
                        scan_state = SCAN_HEX2;
                        digit_cnt  = '0;
                        unit_acc   = '0;
                    end
                    else
                    begin
                        utf8_encode({16'h0, held_high});
                        held_high = '0;
                        escape_char(b);
                    end
                end
                SCAN_HEX2:
                begin
                    r = add_digit(b);
                    if (r < 0)
                    begin
                        end_string(KIND_ERR);
                    end
                    else if (r > 0)
                    begin
                        // high offset is its low ten bits since 0xD800 has them clear
                        cp = {12'h0, held_high[9:0], 10'h0} + {16'h0, unit_acc} + 32'h2400;
                        if (cp >= 32'h110000)
                        begin
                            end_string(KIND_ERR);
                        end
                        else
                        begin
                            utf8_encode(cp);
                            held_high  = '0;
                            unit_acc   = '0;
                            scan_state = SCAN_TEXT;
                        end
                    end
                end
                default: ;
            endcase
        end
        foreach (step_res[i])
        begin
            if (i < MAX_RESULTS)
            begin
                step_res[i].is_last = (i == step_res.size() - 1);
                expected_bytes = {expected_bytes, step_res[i]};
            end
        end
    endfunction

    // ---------------------------------------------------------------
    // output side: random stall and result check
    // ---------------------------------------------------------------

    always @(posedge clk)
    begin : result_check
        utf8_res_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_bytes.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result byte %02h kind %0d last %0d",
                                          out_byte, kind, run_last));
            end
            else
            begin
                want = expected_bytes.pop_front();
                if (out_byte !== want.data)
                    report_mismatch($sformatf("out_byte %02h, expected %02h",
                                              out_byte, want.data));
                if (kind !== want.kind)
                    report_mismatch($sformatf("kind %0d, expected %0d", kind, want.kind));
                if (run_last !== want.is_last)
                    report_mismatch($sformatf("run_last %0d, expected %0d",
                                              run_last, want.is_last));
            end
        end
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // ---------------------------------------------------------------
    // input side
    // ---------------------------------------------------------------

    task automatic send_item(input logic [7:0] b, input logic oq);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        in_byte    <= b;
        open_quote <= oq;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_item(b, oq);
        items_sent++;
    endtask

    // sender holds off until every result is out
    task automatic wait_all_delivered();
        in_valid <= 1'b0;
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10)
            return 8'h30 + nib;
        // mix upper and lower case letters
        return (($urandom_range(1) != 0) ? 8'h61 : 8'h41) + nib - 8'd10;
    endfunction

    function automatic logic [7:0] pick_plain_char();
        logic [7:0] b;
        do
            b = 8'($urandom_range(32, 255));
        while (b == CH_QUOTE || b == CH_BSLASH);
        return b;
    endfunction

    function automatic logic [7:0] pick_bad_hex();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (hex_nibble(b) >= 0);
        return b;
    endfunction

    function automatic logic [7:0] pick_simple_escape();
        case ($urandom_range(7))
            0: return CH_QUOTE;
            1: return CH_BSLASH;
            2: return CH_SLASH;
            3: return CH_B;
            4: return CH_F;
            5: return CH_N;
            6: return CH_R;
            default: return CH_T;
        endcase
    endfunction

    function automatic logic [7:0] pick_unknown_escape();
        logic [7:0] b;
        do
            b = 8'($urandom_range(1, 255));
        while (b inside {CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T, CH_U});
        return b;
    endfunction

    task automatic send_digits(input logic [15:0] u, input int count);
        for (int i = 3; i > 3 - count; i--)
            send_item(hex_char(u[4*i +: 4]), 1'b0);
    endtask

    task automatic send_unicode_escape(input logic [15:0] u);
        send_item(CH_BSLASH, 1'b0);
        send_item(CH_U, 1'b0);
        send_digits(u, 4);
    endtask

    // one piece of string content, mostly well-formed
    task automatic send_token();
        logic [15:0] hi;
        hi = 16'($urandom_range('hD800, 'hDBFF));
        case ($urandom_range(11))
            0, 1, 2, 3: send_item(pick_plain_char(), 1'b0);
            4:
            begin
                send_item(CH_BSLASH, 1'b0);
                send_item(pick_simple_escape(), 1'b0);
            end
            5:
            begin
                send_item(CH_BSLASH, 1'b0);
                send_item(pick_unknown_escape(), 1'b0);
            end
            6: send_unicode_escape(16'($urandom_range(0, 'h7F)));
            7: send_unicode_escape(16'($urandom_range('h80, 'h7FF)));
            8: send_unicode_escape(16'($urandom_range('h800, 'hFFFF)));
            9:
            begin
                // surrogate pair, now and then with an arbitrary second unit
                send_unicode_escape(hi);
                if ($urandom_range(4) == 0)
                    send_unicode_escape(16'($urandom_range(0, 'hFFFF)));
                else
                    send_unicode_escape(16'($urandom_range('hDC00, 'hDFFF)));
            end
            10: send_unicode_escape(hi);   // lone high, next byte decides
            default:
            begin
                // lone high followed by a different escape
                send_unicode_escape(hi);
                send_item(CH_BSLASH, 1'b0);
                if ($urandom_range(1) != 0)
                    send_item(pick_simple_escape(), 1'b0);
                else
                    send_item(pick_unknown_escape(), 1'b0);
            end
        endcase
    endtask

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    task automatic test_directed_cases();
        send_item(8'h00, 1'b0);            // byte while idle is ignored
        send_item(CH_QUOTE, 1'b1);
        send_item(8'hFF, 1'b0);
        send_item(8'h20, 1'b0);
        send_item(CH_BSLASH, 1'b0);
        send_item(CH_N, 1'b0);
        send_item(CH_BSLASH, 1'b0);        // unknown escape dropped
        send_item(CH_Q, 1'b0);
        send_unicode_escape(16'hDBFF);     // pair above the unicode range
        send_unicode_escape(16'hFFFF);
        send_item(CH_QUOTE, 1'b1);
        send_item(CH_BSLASH, 1'b0);        // backslash then nul
        send_item(CH_NUL, 1'b0);
        send_item(CH_QUOTE, 1'b1);
        send_item(8'h1F, 1'b0);            // control byte
        send_item(CH_QUOTE, 1'b1);
        send_item(CH_QUOTE, 1'b0);         // empty string
    endtask

    task automatic test_well_formed_strings(input int n);
        int target;
        target = items_sent + n;
        while (items_sent < target)
        begin
            send_item(CH_QUOTE, 1'b1);
            repeat ($urandom_range(0, 8)) send_token();
            send_item(CH_QUOTE, 1'b0);
        end
    endtask

    task automatic test_broken_strings(input int n);
        int target;
        target = items_sent + n;
        while (items_sent < target)
        begin
            send_item(CH_QUOTE, 1'b1);
            repeat ($urandom_range(0, 3)) send_token();
            case ($urandom_range(6))
                0: send_item(8'($urandom_range(0, 31)), 1'b0);
                1:
                begin
                    send_item(CH_BSLASH, 1'b0);
                    send_item(CH_NUL, 1'b0);
                end
                2:
                begin
                    // bad digit in the first unit
                    send_item(CH_BSLASH, 1'b0);
                    send_item(CH_U, 1'b0);
                    send_digits(16'($urandom_range(0, 'hFFFF)), $urandom_range(0, 3));
                    send_item(pick_bad_hex(), 1'b0);
                end
                3:
                begin
                    // bad digit in the second unit
                    send_unicode_escape(16'($urandom_range('hD800, 'hDBFF)));
                    send_item(CH_BSLASH, 1'b0);
                    send_item(CH_U, 1'b0);
                    send_digits(16'($urandom_range('hDC00, 'hDFFF)), $urandom_range(0, 3));
                    send_item(pick_bad_hex(), 1'b0);
                end
                4:
                begin
                    // pair beyond the last code point
                    send_unicode_escape(16'hDBFF);
                    send_unicode_escape(16'($urandom_range('hE000, 'hFFFF)));
                end
                5:
                begin
                    // new open quote cuts the string, maybe inside an escape
                    if ($urandom_range(1) != 0)
                    begin
                        send_item(CH_BSLASH, 1'b0);
                        send_item(CH_U, 1'b0);
                        send_digits(16'($urandom_range(0, 'hFFFF)), $urandom_range(0, 3));
                    end
                end
                default:
                begin
                    // lone high then a control byte or backslash nul
                    send_unicode_escape(16'($urandom_range('hD800, 'hDBFF)));
                    if ($urandom_range(1) != 0)
                    begin
                        send_item(8'($urandom_range(0, 31)), 1'b0);
                    end
                    else
                    begin
                        send_item(CH_BSLASH, 1'b0);
                        send_item(CH_NUL, 1'b0);
                    end
                end
            endcase
            if ($urandom_range(3) == 0)
                send_item(8'($urandom_range(0, 255)), 1'b0);
        end
    endtask

    task automatic test_stray_bytes(input int n);
        repeat (n) send_item(8'($urandom_range(0, 255)), ($urandom_range(9) == 0));
    endtask

    // ---------------------------------------------------------------
    // sequence
    // ---------------------------------------------------------------

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // no idling
        test_directed_cases();
        test_well_formed_strings(110);
        wait_all_delivered();

        // sender mostly idle
        send_idle_pct = 80;
        test_well_formed_strings(70);
        test_broken_strings(30);

        // receiver mostly stalled
        send_idle_pct  = 0;
        recv_stall_pct = 80;
        test_well_formed_strings(70);
        test_broken_strings(30);

        // both sides idle now and then
        send_idle_pct  = 29;
        recv_stall_pct = 29;
        test_well_formed_strings(70);
        test_broken_strings(30);
        test_stray_bytes(25);

        wait_all_delivered();
        if (err_count == 0)
            $display("** json_string_unescape_utf8_unit: PASSED **");
        else
            $display("** json_string_unescape_utf8_unit: FAILED **");
        $finish;
    end

endmodule

FILE: files.f
+incdir+sv
sv/jsu_pkg.sv
sv/jsu_front.sv
sv/jsu_queue.sv
sv/jsu_back.sv
sv/json_string_unescape_utf8_unit.sv
sv/jsu_checker.sv
tb/sv/testbench.sv
